>>> hw/rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int BODY_DEPTH_DEF = 64;

    localparam logic [7:0] SYNC_FIRST_RST  = 8'h05;
    localparam logic [7:0] SYNC_SECOND_RST = 8'h5a;
    localparam logic [7:0] MIN_LENGTH      = 8'd5;
    localparam logic [7:0] CMD_OFFSET      = 8'd3;

    localparam logic [7:0] CFG_SYNC_FIRST  = 8'd0;
    localparam logic [7:0] CFG_SYNC_SECOND = 8'd1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SUM = 2'd1,
        ST_BAD_LEN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY,
        PH_SUM,
        PH_EMIT_RD,
        PH_EMIT_WR
    } phase_t;

    // controller -> datapath
    typedef struct packed {
        logic len_hi_load;
        logic len_lo_load;
        logic body_take;
        logic emit_err_len;
        logic emit_err_sum;
        logic emit_rd;
        logic emit_load;
    } scfp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_sync1;
        logic is_sync2;
        logic len_bad;
        logic body_done;
        logic sum_match;
        logic emit_last;
        logic out_busy;
    } scfp_sts_t;

endpackage

>>> hw/rtl/scfp_ctrl.sv
// ----------------------------------------------------------------------------
// scfp_ctrl
// Frame state machine: sync hunt, length, body, checksum and body burst.
// ----------------------------------------------------------------------------
module scfp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  scfp_pkg::scfp_sts_t sts,
    output scfp_pkg::scfp_cmd_t cmd
);
    import scfp_pkg::*;

    phase_t state_reg;
    phase_t state_next;
    logic   accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_HUNT1;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // the input is held for the whole burst; bytes that can raise a result wait until the output register can take it
    always_comb
    begin
        case (state_reg)
            PH_EMIT_RD, PH_EMIT_WR: in_stall = 1'b1;
            PH_LEN_LO, PH_SUM:      in_stall = sts.out_busy;
            default:                in_stall = 1'b0;
        endcase
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            PH_HUNT1:
            begin
                if (accept && sts.is_sync1)
                begin
                    state_next = PH_HUNT2;
                end
            end
            PH_HUNT2:
            begin
                if (accept)
                begin
                    if (sts.is_sync2)
                    begin
                        state_next = PH_LEN_HI;
                    end
                    else if (sts.is_sync1)
                    begin
                        state_next = PH_HUNT2;
                    end
                    else
                    begin
                        state_next = PH_HUNT1;
                    end
                end
            end
            PH_LEN_HI:
            begin
                if (accept)
                begin
                    state_next = PH_LEN_LO;
                end
            end
            PH_LEN_LO:
            begin
                if (accept)
                begin
                    state_next = sts.len_bad ? PH_HUNT1 : PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (accept && sts.body_done)
                begin
                    state_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                if (accept)
                begin
                    state_next = sts.sum_match ? PH_EMIT_RD : PH_HUNT1;
                end
            end
            PH_EMIT_RD:
            begin
                state_next = PH_EMIT_WR;
            end
            PH_EMIT_WR:
            begin
                if (!sts.out_busy)
                begin
                    state_next = sts.emit_last ? PH_HUNT1 : PH_EMIT_RD;
                end
            end
            default:
            begin
                state_next = PH_HUNT1;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            PH_LEN_HI:
            begin
                cmd.len_hi_load = accept;
            end
            PH_LEN_LO:
            begin
                cmd.len_lo_load  = accept && !sts.len_bad;
                cmd.emit_err_len = accept && sts.len_bad;
            end
            PH_BODY:
            begin
                cmd.body_take = accept;
            end
            PH_SUM:
            begin
                cmd.emit_err_sum = accept && !sts.sum_match;
            end
            PH_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            PH_EMIT_WR:
            begin
                cmd.emit_load = !sts.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    a_rd_then_wr: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == PH_EMIT_RD |=> state_reg == PH_EMIT_WR)
        else $error("burst read not followed by load");

    a_no_take_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_EMIT_RD || state_reg == PH_EMIT_WR) |-> in_stall)
        else $error("byte taken during burst");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_load || cmd.emit_err_len || cmd.emit_err_sum) |-> !sts.out_busy)
        else $error("result written into busy output register");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.emit_load, cmd.emit_err_len, cmd.emit_err_sum}) <= 1)
        else $error("two result sources at once");

endmodule

>>> hw/rtl/scfp_dp.sv
// ----------------------------------------------------------------------------
// scfp_dp
// Datapath: sync registers, length, running sum, body memory, output register.
// ----------------------------------------------------------------------------
module scfp_dp
#(
    parameter int BODY_DEPTH = scfp_pkg::BODY_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic [7:0]          rx_byte,
    input  scfp_pkg::scfp_cmd_t cmd,
    output scfp_pkg::scfp_sts_t sts,
    output logic [7:0]          payload_byte,
    output logic                last,
    output logic [1:0]          status,
    output logic                out_valid,
    input  logic                out_stall
);
    import scfp_pkg::*;

    localparam int IW = (BODY_DEPTH > 1) ? $clog2(BODY_DEPTH) : 1;
    localparam int CW = $clog2(BODY_DEPTH + 1);
    localparam logic [8:0] DEPTH9 = 9'(BODY_DEPTH);

    logic [7:0]    sync_first_reg;
    logic [7:0]    sync_second_reg;
    logic [7:0]    len_hi_reg;
    logic [7:0]    frame_length_reg;
    logic [7:0]    frame_position_reg;
    logic [7:0]    running_sum_reg;
    logic [CW-1:0] body_count_reg;
    logic [CW-1:0] rd_idx_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    body_store [BODY_DEPTH];

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_last_reg;
    status_t       out_status_reg;

    logic [7:0]    len_full;
    logic [8:0]    pos_inc;
    logic          store_en;

    assign len_full = len_hi_reg | rx_byte;
    assign pos_inc  = {1'b0, frame_position_reg} + 9'd1;
    assign store_en = cmd.body_take && (frame_position_reg >= CMD_OFFSET)
                      && (body_count_reg < CW'(BODY_DEPTH));

    always_comb
    begin
        sts.is_sync1  = (rx_byte == sync_first_reg);
        sts.is_sync2  = (rx_byte == sync_second_reg);
        sts.len_bad   = (len_full < MIN_LENGTH)
                        || (({1'b0, len_full} - 9'd4) > DEPTH9);
        sts.body_done = pos_inc >= ({1'b0, frame_length_reg} - 9'd1);
        sts.sum_match = (rx_byte == running_sum_reg);
        sts.emit_last = ((rd_idx_reg + CW'(1)) == body_count_reg);
        sts.out_busy  = out_valid_reg && out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data;
            end
            else if (cfg_index == CFG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_hi_reg         <= '0;
            frame_length_reg   <= '0;
            frame_position_reg <= '0;
            running_sum_reg    <= '0;
            body_count_reg     <= '0;
            rd_idx_reg         <= '0;
        end
        else
        begin
            if (cmd.len_hi_load)
            begin
                len_hi_reg <= rx_byte;
            end
            if (cmd.len_lo_load)
            begin
                frame_length_reg   <= len_full;
                frame_position_reg <= '0;
                running_sum_reg    <= '0;
                body_count_reg     <= '0;
                rd_idx_reg         <= '0;
            end
            if (cmd.body_take)
            begin
                running_sum_reg    <= running_sum_reg + rx_byte;
                frame_position_reg <= pos_inc[7:0];
            end
            if (store_en)
            begin
                body_count_reg <= body_count_reg + CW'(1);
            end
            if (cmd.emit_load)
            begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            body_store[body_count_reg[IW-1:0]] <= rx_byte;
        end
        if (cmd.emit_rd)
        begin
            rd_data_reg <= body_store[rd_idx_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load || cmd.emit_err_len || cmd.emit_err_sum)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= sts.emit_last;
            out_status_reg <= ST_OK;
        end
        else if (cmd.emit_err_len || cmd.emit_err_sum)
        begin
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
            out_status_reg <= cmd.emit_err_len ? ST_BAD_LEN : ST_BAD_SUM;
        end
    end

    assign out_valid    = out_valid_reg;
    assign payload_byte = out_byte_reg;
    assign last         = out_last_reg;
    assign status       = out_status_reg;

endmodule

>>> hw/rtl/sum_checked_frame_parser.sv
// ----------------------------------------------------------------------------
// sum_checked_frame_parser
// Byte-stream parser for sync/length/checksum framed commands.
// ----------------------------------------------------------------------------
// Input channel rx_byte/in_valid/in_stall takes one received byte per transfer.
// The parser hunts for the two sync bytes, reads length L = byte2 | byte3,
// sums bytes 4..2+L mod 256 and buffers bytes 7..2+L, then checks the sum
// against byte 3+L.
// Output channel payload_byte/last/status/out_valid/out_stall: a good frame
// gives its L-4 command bytes (status 0, last on the final one); a bad sum
// gives one status 1 result, a bad length one status 2 result right after
// the second length byte.
// Throughput: one byte per cycle while parsing, but a result-producing byte
// stalls while the output register is full and stalled. After a good
// checksum the input stalls for the burst: each command byte takes a
// registered body memory read, then an output register load, which waits
// while out_stall holds. A result is registered and visible the cycle
// after the byte (or load) that produces it.
// Configuration port cfg_valid/cfg_ready/cfg_index/cfg_data is always ready;
// index 0 is sync_first, 1 is sync_second, other indexes are ignored.
// Reset (rst_n low) restores the sync bytes 0x05/0x5a and returns to hunting.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser
#(
    parameter int BODY_DEPTH = scfp_pkg::BODY_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic [7:0] rx_byte,
    input  logic       in_valid,
    output logic       in_stall,
    output logic [7:0] payload_byte,
    output logic       last,
    output logic [1:0] status,
    output logic       out_valid,
    input  logic       out_stall
);
    import scfp_pkg::*;

    scfp_cmd_t cmd;
    scfp_sts_t sts;

    assign cfg_ready = 1'b1;

    scfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    scfp_dp
    #(
        .BODY_DEPTH (BODY_DEPTH)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .payload_byte (payload_byte),
        .last         (last),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sync/length/checksum frame parser.
// ----------------------------------------------------------------------------
// A table of directed bytes covers the sync hunt, the length errors, a
// one-byte good frame and a checksum error. Random frames follow under
// several sync settings. Every accepted byte runs through a parser model
// in the bench; each output transfer is checked against the oldest result
// due from the table or that model. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import scfp_pkg::*;

    localparam int BODY_DEPTH    = BODY_DEPTH_DEF;
    localparam int MAX_LENGTH    = BODY_DEPTH + 4;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PCT      = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0] payload;
        logic       last;
        status_t    status;
    } frame_result_t;

    typedef struct packed {
        logic [7:0]    rx;
        logic          fixed;
        frame_result_t result;
    } stim_row_t;

    localparam frame_result_t NO_RESULT = '{8'h00, 1'b0, ST_OK};
    localparam frame_result_t LEN_ERR   = '{8'h00, 1'b1, ST_BAD_LEN};
    localparam frame_result_t SUM_ERR   = '{8'h00, 1'b1, ST_BAD_SUM};
    localparam frame_result_t ONE_CMD   = '{8'hff, 1'b1, ST_OK};

    localparam int DIR_ROWS = 34;
    // defaults after reset: sync 05 5a
    localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{8'h77, 1'b0, NO_RESULT},          // line noise
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h77, 1'b0, NO_RESULT},          // broken sync
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h05, 1'b0, NO_RESULT},          // first sync repeated
        '{8'h5a, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, LEN_ERR},            // L = 0
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h5a, 1'b0, NO_RESULT},
        '{8'hff, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, LEN_ERR},            // L = 255
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h5a, 1'b0, NO_RESULT},
        '{8'h44, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, LEN_ERR},            // L = 69, one past the buffer
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h5a, 1'b0, NO_RESULT},
        '{8'h04, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},          // L = 5, shortest good frame
        '{8'h10, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, NO_RESULT},
        '{8'h30, 1'b0, NO_RESULT},
        '{8'hff, 1'b0, NO_RESULT},
        '{8'h5f, 1'b1, ONE_CMD},
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h5a, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h05, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b1, SUM_ERR}             // sum 00, checksum 01
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data  = 8'h00;
    logic [7:0] rx_byte   = 8'h00;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] payload_byte;
    logic       last;
    logic [1:0] status;
    logic       out_valid;
    logic       out_stall = 1'b0;

    // bench copy of the parser state and registers
    logic [7:0] sync_a = SYNC_FIRST_RST;
    logic [7:0] sync_b = SYNC_SECOND_RST;
    phase_t     pr_phase = PH_HUNT1;
    logic [7:0] pr_pos = 8'h00;
    logic [7:0] pr_len = 8'h00;
    logic [7:0] pr_sum = 8'h00;
    logic [6:0] pr_count = 7'd0;
    logic [7:0] pr_body [BODY_DEPTH];

    frame_result_t step_results [$];
    frame_result_t due_results [$];

    logic quiet = 1'b0;
    int   failures = 0;
    int   results_checked = 0;
    int   bytes_sent = 0;
    int   noise_sent = 0;
    int   good_frames = 0;

    sum_checked_frame_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .payload_byte (payload_byte),
        .last         (last),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

    always #1 clk = ~clk;

    // advance the parser by one byte, leaving its results in step_results
    function automatic void parse_byte(input logic [7:0] b);
        frame_result_t r;
        int i;
        case (pr_phase)
            PH_HUNT1:
                if (b == sync_a)
                    pr_phase = PH_HUNT2;
            PH_HUNT2:
                if (b == sync_b)
                    pr_phase = PH_LEN_HI;
                else if (b == sync_a)
                    pr_phase = PH_HUNT2;
                else
                    pr_phase = PH_HUNT1;
            PH_LEN_HI:
            begin
                pr_len   = b;
                pr_phase = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                pr_len = pr_len | b;
                if (pr_len < MIN_LENGTH || int'(pr_len) > MAX_LENGTH)
                begin
                    step_results.push_back(LEN_ERR);
                    pr_phase = PH_HUNT1;
                end
                else
                begin
                    pr_pos   = 8'h00;
                    pr_sum   = 8'h00;
                    pr_count = 7'd0;
                    pr_phase = PH_BODY;
                end
            end
            PH_BODY:
            begin
                pr_sum = pr_sum + b;
                if (pr_pos >= CMD_OFFSET && int'(pr_count) < BODY_DEPTH)
                begin
                    pr_body[pr_count] = b;
                    pr_count++;
                end
                pr_pos++;
                if (int'(pr_pos) >= int'(pr_len) - 1)
                    pr_phase = PH_SUM;
            end
            PH_SUM:
            begin
                if (b == pr_sum)
                begin
                    for (i = 0; i < int'(pr_count); i++)
                    begin
                        r.payload = pr_body[i];
                        r.last    = (i + 1 == int'(pr_count));
                        r.status  = ST_OK;
                        step_results.push_back(r);
                    end
                end
                else
                    step_results.push_back(SUM_ERR);
                pr_phase = PH_HUNT1;
            end
            default:
                pr_phase = PH_HUNT1;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fixed = 1'b0,
                             input frame_result_t fixed_res = NO_RESULT);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge
        step_results.delete();
        parse_byte(b);
        if (fixed)
            due_results.push_back(fixed_res);
        else
            foreach (step_results[k])
                due_results.push_back(step_results[k]);
        bytes_sent++;
    endtask

    // length split across both length bytes so that the OR matters
    task automatic send_header(input logic [7:0] len);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = len & 8'($urandom);
        lo = (len & ~hi) | (hi & 8'($urandom));
        send_byte(sync_a);
        send_byte(sync_b);
        send_byte(hi);
        send_byte(lo);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'h00;
        send_header(len);
        repeat (int'(len) - 1)
        begin
            b = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        if (corrupt)
            send_byte(sum ^ 8'($urandom_range(1, 255)));
        else
        begin
            send_byte(sum);
            good_frames++;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // sync bytes plus one write to an unmapped index, which must be ignored
    task automatic reconfigure(input logic [7:0] first, input logic [7:0] second);
        logic [7:0] idx [3];
        logic [7:0] val [3];
        int i;
        wait_idle();
        idx[0] = CFG_SYNC_FIRST;
        val[0] = first;
        idx[1] = CFG_SYNC_SECOND;
        val[1] = second;
        idx[2] = 8'($urandom_range(255, CFG_SYNC_SECOND + 1));
        val[2] = 8'($urandom);
        for (i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx[i] == CFG_SYNC_FIRST)
                sync_a = val[i];
            else if (idx[i] == CFG_SYNC_SECOND)
                sync_b = val[i];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input int min_bytes);
        int start;
        int pick;
        int len;
        logic [7:0] b;
        start = bytes_sent - noise_sent;
        while (bytes_sent - noise_sent - start < min_bytes)
        begin
            pick = $urandom_range(0, 99);
            // mostly short frames, now and then up to the full buffer
            if ($urandom_range(0, 14) == 0)
                len = $urandom_range(13, MAX_LENGTH);
            else
                len = $urandom_range(MIN_LENGTH, 12);
            if (pick < 60)
                send_frame(8'(len), 1'b0);
            else if (pick < 70)
                send_frame(8'(len), 1'b1);
            else if (pick < 80)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_header(8'($urandom_range(0, MIN_LENGTH - 1)));
                else
                    send_header(8'($urandom_range(MAX_LENGTH + 1, 255)));
            end
            else if (pick < 88)
            begin
                send_byte(sync_a);
                if (sync_a != sync_b && $urandom_range(0, 3) == 0)
                    b = sync_a;
                else
                begin
                    b = 8'($urandom);
                    if (b == sync_b)
                        b = b ^ 8'h01;
                end
                send_byte(b);
            end
            else if (pick < 95)
            begin
                repeat ($urandom_range(1, 3))
                begin
                    send_byte(8'($urandom));
                    noise_sent++;
                end
            end
            else
            begin
                // cut short: the next bytes land in this frame's body
                send_header(8'(len));
                repeat ($urandom_range(0, len - 2))
                    send_byte(8'($urandom));
            end
        end
    endtask

    task automatic record_failure(input string what, input frame_result_t want,
                                  input frame_result_t got);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("%s: expected payload %02h last %0b status %0d, %s",
                     what, want.payload, want.last, want.status,
                     $sformatf("got payload %02h last %0b status %0d",
                               got.payload, got.last, got.status));
    endtask

    always @(posedge clk)
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        frame_result_t got;
        frame_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.payload = payload_byte;
            got.last    = last;
            got.status  = status_t'(status);
            if (due_results.size() == 0)
                record_failure("unexpected result", NO_RESULT, got);
            else
            begin
                want = due_results.pop_front();
                if (got.payload !== want.payload || got.last !== want.last ||
                    got.status !== want.status)
                    record_failure("result mismatch", want, got);
                results_checked++;
            end
        end
    end

    initial
    begin
        int i;
        logic [7:0] v;
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].fixed,
                      DIRECTED_ROWS[i].result);

        // a long stretch with no idling on either side: one full-buffer frame
        quiet = 1'b1;
        reconfigure(8'h00, 8'hff);
        send_frame(8'(MAX_LENGTH), 1'b0);
        quiet = 1'b0;

        // both sync bytes equal
        v = 8'($urandom);
        reconfigure(v, v);
        run_random(6);

        reconfigure(8'($urandom), 8'($urandom));
        run_random(6);

        wait_idle();

        $display("covered %0d bytes (%0d noise) over four sync settings",
                 bytes_sent, noise_sent);
        $display("%0d good frames sent, %0d results checked, %0d failures",
                 good_frames, results_checked, failures);
        if (failures == 0 && due_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
